// File: hw/rtl/esd_pkg.sv
// shared types, constants and decode helpers for the escape string decoder
package esd_pkg;

    localparam int MAX_LITERAL_LEN = 4096;
    localparam int IDX_W           = $clog2(MAX_LITERAL_LEN);
    localparam int POS_W           = 12;
    localparam int MAX_RESULTS     = 4;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LITERAL_LEN - 1);

    // decoder modes
    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_ESCAPE  = 2'd1;
    localparam logic [1:0] MODE_DIGITS  = 2'd2;
    localparam logic [1:0] MODE_DISCARD = 2'd3;

    // escape kinds
    localparam logic [1:0] KIND_X  = 2'd0;
    localparam logic [1:0] KIND_U4 = 2'd1;
    localparam logic [1:0] KIND_U8 = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd1;
    localparam logic [2:0] ERR_FEW_DIGIT = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN   = 3'd3;
    localparam logic [2:0] ERR_TOO_BIG   = 3'd4;

    // characters
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_LV    = 8'h76;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_UU    = 8'h55;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam logic [31:0] CP_MAX = 32'h0010_FFFF;

    typedef struct packed {
        logic             has_byte;
        logic [7:0]       out_byte;
        logic             out_last;
        logic [2:0]       error_code;
        logic [POS_W-1:0] error_pos;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]             cnt;
        t_result [MAX_RESULTS-1:0]    res;
    } t_group;

    function automatic t_result mk_byte(logic [7:0] b, logic last);
        t_result r;
        r.has_byte   = 1'b1;
        r.out_byte   = b;
        r.out_last   = last;
        r.error_code = ERR_NONE;
        r.error_pos  = '0;
        return r;
    endfunction

    function automatic t_result mk_error(logic [2:0] code, logic [IDX_W-1:0] pos);
        t_result r;
        r.has_byte   = 1'b0;
        r.out_byte   = '0;
        r.out_last   = 1'b1;
        r.error_code = code;
        r.error_pos  = POS_W'(pos);
        return r;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [7:0] t;
        logic [4:0] r;
        t = '0;
        r = '0;
        case (c) inside
            [CH_0:CH_9]: begin
                t = c - CH_0;
                r = {1'b1, t[3:0]};
            end
            [CH_LA:CH_LF]: begin
                t = c - CH_LA + 8'd10;
                r = {1'b1, t[3:0]};
            end
            [CH_UA:CH_UF]: begin
                t = c - CH_UA + 8'd10;
                r = {1'b1, t[3:0]};
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // {valid, byte}
    function automatic logic [8:0] simple_escape(logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_0:     r = {1'b1, 8'h00};
            CH_LA:    r = {1'b1, 8'h07};
            CH_LB:    r = {1'b1, 8'h08};
            CH_LT:    r = {1'b1, 8'h09};
            CH_LN:    r = {1'b1, 8'h0A};
            CH_LF:    r = {1'b1, 8'h0C};
            CH_LR:    r = {1'b1, 8'h0D};
            CH_LV:    r = {1'b1, 8'h0B};
            CH_BSL:   r = {1'b1, 8'h5C};
            CH_APOS:  r = {1'b1, 8'h27};
            CH_QUOTE: r = {1'b1, 8'h22};
            default:  r = '0;
        endcase
        return r;
    endfunction

    // code point at or below the maximum, 1 to 4 bytes
    function automatic t_group utf8_group(logic [20:0] cp, logic last);
        t_group g;
        g = '0;
        if (cp < 21'h80) begin
            g.cnt    = CNT_W'(1);
            g.res[0] = mk_byte({1'b0, cp[6:0]}, last);
        end else if (cp < 21'h800) begin
            g.cnt    = CNT_W'(2);
            g.res[0] = mk_byte({3'b110, cp[10:6]}, 1'b0);
            g.res[1] = mk_byte({2'b10, cp[5:0]}, last);
        end else if (cp < 21'h10000) begin
            g.cnt    = CNT_W'(3);
            g.res[0] = mk_byte({4'b1110, cp[15:12]}, 1'b0);
            g.res[1] = mk_byte({2'b10, cp[11:6]}, 1'b0);
            g.res[2] = mk_byte({2'b10, cp[5:0]}, last);
        end else begin
            g.cnt    = CNT_W'(4);
            g.res[0] = mk_byte({5'b11110, cp[20:18]}, 1'b0);
            g.res[1] = mk_byte({2'b10, cp[17:12]}, 1'b0);
            g.res[2] = mk_byte({2'b10, cp[11:6]}, 1'b0);
            g.res[3] = mk_byte({2'b10, cp[5:0]}, last);
        end
        return g;
    endfunction

endpackage

// File: hw/rtl/esd_stream_if.sv
// valid/ready channel interfaces for literal bytes in and decoded results out
interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_out_if;
    logic                     valid;
    logic                     ready;
    logic                     has_byte;
    logic [7:0]               out_byte;
    logic                     out_last;
    logic [2:0]               error_code;
    logic [esd_pkg::POS_W-1:0] error_pos;

    modport source (output valid, output has_byte, output out_byte, output out_last,
                    output error_code, output error_pos, input ready);
    modport sink   (input valid, input has_byte, input out_byte, input out_last,
                    input error_code, input error_pos, output ready);
endinterface

// File: hw/rtl/escape_string_decoder_core.sv
// top level of the escape string decoder
//
// decodes one escaped string literal, one byte per input item, into result items
// input channel i_in: in_byte and in_last, in_last marks the final byte of a literal
// output channel o_out: one result item per handshake; has_byte/out_byte carry a
//   decoded byte, out_last marks the final result of the literal, error_code and
//   error_pos report the first error, after which input is dropped up to in_last
// an input byte is decoded in the cycle it is accepted and its results (0 to 4)
//   are registered in the result group buffer, so the first result shows in the
//   cycle after acceptance
// throughput: one input item per cycle while the receiver takes every result and
//   each byte gives at most one result; a \u or \U escape that gives n UTF-8 bytes
//   holds off the input until the single-result output port has drained the group buffer
// the next byte is taken while the last waiting result is handed over
// reset (synchronous, active low) empties the buffer and returns the decoder to
//   pass-through with byte index zero
// when the receiver stalls, the waiting result holds and input is held off while
//   a result waits that does not leave this cycle
module escape_string_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    esd_in_if.sink     i_in,
    esd_out_if.source  o_out
);

    logic             in_accept;
    logic             out_take;
    logic             can_load;
    logic             out_valid;
    esd_pkg::t_group  group;
    esd_pkg::t_result head;

    assign in_accept = i_in.valid && can_load;
    assign out_take  = out_valid && o_out.ready;

    // byte decode and escape state
    esd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in.in_byte),
        .i_last   (i_in.in_last),
        .o_group  (group)
    );

    // results waiting for the receiver
    esd_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_accept),
        .i_group    (group),
        .i_take     (out_take),
        .o_can_load (can_load),
        .o_valid    (out_valid),
        .o_head     (head)
    );

    assign i_in.ready       = can_load;
    assign o_out.valid      = out_valid;
    assign o_out.has_byte   = head.has_byte;
    assign o_out.out_byte   = head.out_byte;
    assign o_out.out_last   = head.out_last;
    assign o_out.error_code = head.error_code;
    assign o_out.error_pos  = head.error_pos;

endmodule

// File: hw/rtl/esd_decode.sv
// escape state registers and the per-byte decode into a result group
module esd_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output esd_pkg::t_group o_group
);

    logic [1:0]                r_mode, n_mode;
    logic [1:0]                r_kind, n_kind;
    logic [3:0]                r_digits, n_digits;
    logic [31:0]               r_accum, n_accum;
    logic [esd_pkg::IDX_W-1:0] r_index, n_index;

    logic [esd_pkg::IDX_W-1:0] idx_next;
    logic [4:0]                hex;
    logic [8:0]                simple;
    logic [31:0]               acc_new;
    logic [3:0]                dig_new;
    logic [2:0]                err;
    logic [esd_pkg::IDX_W-1:0] epos;
    esd_pkg::t_group           grp;

    assign idx_next = (r_index == esd_pkg::IDX_LAST) ? r_index : r_index + 1'b1;
    assign hex      = esd_pkg::hex_value(i_byte);
    assign simple   = esd_pkg::simple_escape(i_byte);
    assign acc_new  = {r_accum[27:0], hex[3:0]};
    assign dig_new  = r_digits - 4'd1;

    always_comb begin
        n_mode   = r_mode;
        n_kind   = r_kind;
        n_digits = r_digits;
        n_accum  = r_accum;
        err      = esd_pkg::ERR_NONE;
        epos     = '0;
        grp      = '0;

        case (r_mode)
            esd_pkg::MODE_DISCARD: begin
                grp = '0;
            end
            esd_pkg::MODE_ESCAPE: begin
                if (simple[8]) begin
                    grp.cnt    = esd_pkg::CNT_W'(1);
                    grp.res[0] = esd_pkg::mk_byte(simple[7:0], i_last);
                    n_mode     = esd_pkg::MODE_NORMAL;
                end else if (i_byte == esd_pkg::CH_LX || i_byte == esd_pkg::CH_LU
                             || i_byte == esd_pkg::CH_UU) begin
                    if (i_byte == esd_pkg::CH_LX) begin
                        n_kind   = esd_pkg::KIND_X;
                        n_digits = 4'd2;
                    end else if (i_byte == esd_pkg::CH_LU) begin
                        n_kind   = esd_pkg::KIND_U4;
                        n_digits = 4'd4;
                    end else begin
                        n_kind   = esd_pkg::KIND_U8;
                        n_digits = 4'd8;
                    end
                    n_accum = '0;
                    n_mode  = esd_pkg::MODE_DIGITS;
                    if (i_last) begin
                        err  = esd_pkg::ERR_FEW_DIGIT;
                        epos = idx_next;
                    end
                end else begin
                    err  = esd_pkg::ERR_UNKNOWN;
                    epos = r_index;
                end
            end
            esd_pkg::MODE_DIGITS: begin
                if (!hex[4]) begin
                    err  = (i_byte == esd_pkg::CH_QUOTE) ? esd_pkg::ERR_FEW_DIGIT
                                                          : esd_pkg::ERR_BAD_HEX;
                    epos = r_index;
                end else begin
                    n_accum  = acc_new;
                    n_digits = dig_new;
                    if (dig_new == 4'd0) begin
                        n_mode = esd_pkg::MODE_NORMAL;
                        if (r_kind == esd_pkg::KIND_X) begin
                            grp.cnt    = esd_pkg::CNT_W'(1);
                            grp.res[0] = esd_pkg::mk_byte(acc_new[7:0], i_last);
                        end else if (acc_new > esd_pkg::CP_MAX) begin
                            err  = esd_pkg::ERR_TOO_BIG;
                            epos = r_index;
                        end else begin
                            grp = esd_pkg::utf8_group(acc_new[20:0], i_last);
                        end
                    end else if (i_last) begin
                        err  = esd_pkg::ERR_FEW_DIGIT;
                        epos = idx_next;
                    end
                end
            end
            default: begin
                if (i_byte == esd_pkg::CH_BSL) begin
                    n_mode = esd_pkg::MODE_ESCAPE;
                    if (i_last) begin
                        err  = esd_pkg::ERR_UNKNOWN;
                        epos = idx_next;
                    end
                end else begin
                    grp.cnt    = esd_pkg::CNT_W'(1);
                    grp.res[0] = esd_pkg::mk_byte(i_byte, i_last);
                end
            end
        endcase

        // first error ends the literal
        if (err != esd_pkg::ERR_NONE) begin
            grp        = '0;
            grp.cnt    = esd_pkg::CNT_W'(1);
            grp.res[0] = esd_pkg::mk_error(err, epos);
            n_mode     = esd_pkg::MODE_DISCARD;
        end

        if (i_last) begin
            n_mode   = esd_pkg::MODE_NORMAL;
            n_kind   = esd_pkg::KIND_X;
            n_digits = '0;
            n_accum  = '0;
            n_index  = '0;
        end else begin
            n_index  = idx_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= esd_pkg::MODE_NORMAL;
            r_kind   <= esd_pkg::KIND_X;
            r_digits <= '0;
            r_accum  <= '0;
            r_index  <= '0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_kind   <= n_kind;
            r_digits <= n_digits;
            r_accum  <= n_accum;
            r_index  <= n_index;
        end
    end

    assign o_group = grp;

endmodule

// File: hw/rtl/esd_out_buf.sv
// result group register, drained one result per output handshake
module esd_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  esd_pkg::t_group i_group,
    input  logic            i_take,
    output logic            o_can_load,
    output logic            o_valid,
    output esd_pkg::t_result o_head
);

    logic [esd_pkg::CNT_W-1:0]                   r_cnt, n_cnt;
    esd_pkg::t_result [esd_pkg::MAX_RESULTS-1:0] r_res, n_res;

    // free now, or the only waiting result leaves this cycle
    assign o_can_load = (r_cnt == '0) || (r_cnt == esd_pkg::CNT_W'(1) && i_take);
    assign o_valid    = (r_cnt != '0);
    assign o_head     = r_res[0];

    always_comb begin
        n_cnt = r_cnt;
        n_res = r_res;
        if (i_load) begin
            n_cnt = i_group.cnt;
            n_res = i_group.res;
        end else if (i_take) begin
            n_cnt = r_cnt - 1'b1;
            for (int i = 0; i < esd_pkg::MAX_RESULTS - 1; i++) begin
                n_res[i] = r_res[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

// File: hw/rtl/esd_checker.sv
// port-level checks on the result channel of the escape string decoder
module esd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      i_ready,
    input logic                      i_has_byte,
    input logic [7:0]                i_out_byte,
    input logic                      i_out_last,
    input logic [2:0]                i_error_code,
    input logic [esd_pkg::POS_W-1:0] i_error_pos
);

    // nothing waits right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    // an error result ends the literal and carries no byte
    a_error_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_error_code != esd_pkg::ERR_NONE |-> i_out_last && !i_has_byte
            && i_out_byte == 8'h00)
        else $error("error result without end mark or with a byte");

    // a byte result reports no error code and no error position
    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_has_byte |-> i_error_code == esd_pkg::ERR_NONE && i_error_pos == '0)
        else $error("byte result carries error fields");

    // a result item without a byte is always an error
    a_nobyte_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_has_byte |-> i_error_code != esd_pkg::ERR_NONE)
        else $error("empty result without error code");

    // stalled result stays valid and keeps its byte and end mark
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("stalled result changed");

endmodule

bind escape_string_decoder_core esd_checker u_esd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_has_byte   (o_out.has_byte),
    .i_out_byte   (o_out.out_byte),
    .i_out_last   (o_out.out_last),
    .i_error_code (o_out.error_code),
    .i_error_pos  (o_out.error_pos)
);
